[src/can_frame_sensor_decoder_assert.svh]
// Assertion macros shared by the CAN sensor decoder modules.
`ifndef CAN_FRAME_SENSOR_DECODER_ASSERT_SVH
`define CAN_FRAME_SENSOR_DECODER_ASSERT_SVH

// same-cycle implication
`define CFSD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cfsd_pkg.sv]
// Shared types, frame codes and calibration tables for the CAN sensor decoder.
package cfsd_pkg;

    localparam int TABLE_POINTS = 39;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int RAW_W        = 16;
    localparam int TEMP_W       = 9;
    localparam int DY_W         = TEMP_W + 1;
    localparam int NUM_W        = RAW_W + DY_W;
    localparam int CNT_W        = $clog2(NUM_W);
    localparam int FIFO_DEPTH   = 2;

    localparam logic [10:0] ID_BRAKE  = 11'h100;
    localparam logic [10:0] ID_FLAGS  = 11'h101;
    localparam logic [10:0] ID_INVREG = 11'h103;
    localparam logic [7:0]  SUB_INV   = 8'h4A;
    localparam logic [7:0]  SUB_MOT   = 8'h49;

    localparam logic [1:0] KIND_BRAKE = 2'd0;
    localparam logic [1:0] KIND_FLAGS = 2'd1;
    localparam logic [1:0] KIND_INV   = 2'd2;
    localparam logic [1:0] KIND_MOT   = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_POINTS - 1);

    localparam logic [RAW_W-1:0] NTC_RAW [TABLE_POINTS] = '{
        16'd16245, 16'd16308, 16'd16387, 16'd16487, 16'd16609, 16'd16759, 16'd16938,
        16'd17151, 16'd17400, 16'd17688, 16'd18017, 16'd18387, 16'd18797, 16'd19247,
        16'd19733, 16'd20250, 16'd20793, 16'd21357, 16'd21933, 16'd22515, 16'd23097,
        16'd23671, 16'd24232, 16'd24775, 16'd25296, 16'd25792, 16'd26261, 16'd26702,
        16'd27114, 16'd27497, 16'd27851, 16'd28179, 16'd28480, 16'd28757, 16'd29011,
        16'd29243, 16'd29456, 16'd29650, 16'd29827
    };

    localparam logic [RAW_W-1:0] KTY_RAW [TABLE_POINTS] = '{
        16'd7414,  16'd7687,  16'd7962,  16'd8240,  16'd8520,  16'd8802,  16'd9085,
        16'd9369,  16'd9654,  16'd9939,  16'd10225, 16'd10510, 16'd10795, 16'd11080,
        16'd11364, 16'd11646, 16'd11927, 16'd12207, 16'd12485, 16'd12762, 16'd13036,
        16'd13308, 16'd13578, 16'd13846, 16'd14111, 16'd14373, 16'd14633, 16'd14890,
        16'd15144, 16'd15391, 16'd15628, 16'd15852, 16'd16061, 16'd16251, 16'd16421,
        16'd16569, 16'd16692, 16'd16789, 16'd16857
    };

    localparam logic signed [TEMP_W-1:0] DEG_C [TABLE_POINTS] = '{
        -9'sd35, -9'sd30, -9'sd25, -9'sd20, -9'sd15, -9'sd10, -9'sd5,  9'sd0,
         9'sd5,   9'sd10,  9'sd15,  9'sd20,  9'sd25,  9'sd30,  9'sd35, 9'sd40,
         9'sd45,  9'sd50,  9'sd55,  9'sd60,  9'sd65,  9'sd70,  9'sd75, 9'sd80,
         9'sd85,  9'sd90,  9'sd95,  9'sd100, 9'sd105, 9'sd110, 9'sd115, 9'sd120,
         9'sd125, 9'sd130, 9'sd135, 9'sd140, 9'sd145, 9'sd150, 9'sd155
    };

    localparam logic signed [TEMP_W-1:0] DEG_MIN = -9'sd35;
    localparam logic signed [TEMP_W-1:0] DEG_MAX = 9'sd155;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       brake;
        logic             rtd;
        logic             cool;
        logic [RAW_W-1:0] raw;
    } job_t;

    function automatic logic [RAW_W-1:0] tab_raw(input logic motor,
                                                 input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] i;
        i = (idx < IDX_W'(TABLE_POINTS)) ? idx : IDX_LAST;
        return motor ? KTY_RAW[i] : NTC_RAW[i];
    endfunction

    function automatic logic signed [TEMP_W-1:0] tab_deg(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] i;
        i = (idx < IDX_W'(TABLE_POINTS)) ? idx : IDX_LAST;
        return DEG_C[i];
    endfunction

endpackage

[src/can_frame_sensor_decoder.sv]
// With the engine idle, a kept frame is written into the queue and then popped by the engine in ST_IDLE;
// brake, flag and clamped readings go from there straight into the output registers, while
// interpolated readings pass the table search (one point per cycle), the multiply, the 26-step divider
// and ST_FIN before the output registers are loaded. Only one frame is in the engine at a time, and
// a new one is taken only after m_ready accepts the result; the two-entry queue takes frames ahead.
// Reset: synchronous active-low aresetn empties the queue and clears the output valid.
module can_frame_sensor_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [10:0]                       s_frame_id,
    input  logic [7:0]                        s_data_byte0,
    input  logic [7:0]                        s_data_byte1,
    input  logic [7:0]                        s_data_byte2,
    input  logic [7:0]                        s_data_byte4,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_update_kind,
    output logic [7:0]                        m_brake_value,
    output logic                              m_ready_to_drive,
    output logic                              m_cooling_request,
    output logic signed [cfsd_pkg::TEMP_W-1:0] m_temperature
);
    import cfsd_pkg::*;

    logic q_full;
    logic q_push;
    job_t q_in_job;
    logic q_pop;
    logic q_not_empty;
    job_t q_head_job;

    cfsd_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_id   (s_frame_id),
        .s_data_byte0 (s_data_byte0),
        .s_data_byte1 (s_data_byte1),
        .s_data_byte2 (s_data_byte2),
        .s_data_byte4 (s_data_byte4),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_in_job)
    );

    cfsd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_in_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_head_job)
    );

    cfsd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .job_valid         (q_not_empty),
        .job               (q_head_job),
        .job_pop           (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_update_kind     (m_update_kind),
        .m_brake_value     (m_brake_value),
        .m_ready_to_drive  (m_ready_to_drive),
        .m_cooling_request (m_cooling_request),
        .m_temperature     (m_temperature)
    );

endmodule

[src/cfsd_front.sv]
// Front end: accept frames, classify them and build jobs for the queue.
module cfsd_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [10:0]       s_frame_id,
    input  logic [7:0]        s_data_byte0,
    input  logic [7:0]        s_data_byte1,
    input  logic [7:0]        s_data_byte2,
    input  logic [7:0]        s_data_byte4,
    input  logic              q_full,
    output logic              q_push,
    output cfsd_pkg::job_t    q_job
);
    import cfsd_pkg::*;

    logic keep;

    always_comb begin
        q_job     = '0;
        q_job.raw = {s_data_byte2, s_data_byte1};
        keep      = 1'b0;
        if (s_frame_id == ID_BRAKE) begin
            keep        = 1'b1;
            q_job.kind  = KIND_BRAKE;
            q_job.brake = s_data_byte4;
        end else if (s_frame_id == ID_FLAGS) begin
            keep       = 1'b1;
            q_job.kind = KIND_FLAGS;
            q_job.rtd  = s_data_byte1[5];
            q_job.cool = s_data_byte1[6];
        end else if (s_frame_id == ID_INVREG && s_data_byte0 == SUB_INV) begin
            keep       = 1'b1;
            q_job.kind = KIND_INV;
        end else if (s_frame_id == ID_INVREG && s_data_byte0 == SUB_MOT) begin
            keep       = 1'b1;
            q_job.kind = KIND_MOT;
        end
    end

    // drop frames that carry nothing of interest
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

[src/cfsd_fifo.sv]
// Two-entry job queue between the front end and the conversion engine.
`include "can_frame_sensor_decoder_assert.svh"

module cfsd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cfsd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cfsd_pkg::job_t head_job
);
    import cfsd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    job_t                    entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [$clog2(FIFO_DEPTH+1)-1:0] count_reg;

    assign full      = (count_reg == ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `CFSD_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `CFSD_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, not_empty, "pop from empty queue")
    `CFSD_ASSERT_NEXT(a_count_track, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

[src/cfsd_back.sv]
// Back end: table search, multiply and restoring divide for the temperature conversion.
`include "can_frame_sensor_decoder_assert.svh"

module cfsd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    input  cfsd_pkg::job_t                    job,
    output logic                              job_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_update_kind,
    output logic [7:0]                        m_brake_value,
    output logic                              m_ready_to_drive,
    output logic                              m_cooling_request,
    output logic signed [cfsd_pkg::TEMP_W-1:0] m_temperature
);
    import cfsd_pkg::*;

    localparam int SUM_W = DY_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic                     m_valid_reg;
    logic [1:0]               kind_reg;
    logic [7:0]               brake_reg;
    logic                     rtd_reg;
    logic                     cool_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [RAW_W-1:0]         dx_reg;
    logic [RAW_W-1:0]         den_reg;
    logic signed [DY_W-1:0]   dy_reg;
    logic signed [TEMP_W-1:0] y0_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [RAW_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic                     job_motor;
    logic [RAW_W-1:0]         x_first;
    logic [RAW_W-1:0]         x_last;
    logic                     motor;
    logic [IDX_W-1:0]         idx_hi;
    logic [RAW_W-1:0]         x_lo;
    logic [RAW_W-1:0]         x_hi;
    logic signed [DY_W-1:0]   dy_seg;
    logic [DY_W-1:0]          dy_mag;
    logic [NUM_W-1:0]         prod;
    logic [RAW_W:0]           rem_sh;
    logic                     fits;
    logic [RAW_W-1:0]         rem_new;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  sum;

    assign job_motor = (job.kind == KIND_MOT);
    assign x_first   = tab_raw(job_motor, '0);
    assign x_last    = tab_raw(job_motor, IDX_LAST);

    assign motor  = (kind_reg == KIND_MOT);
    assign idx_hi = idx_reg + 1'b1;
    assign x_lo   = tab_raw(motor, idx_reg);
    assign x_hi   = tab_raw(motor, idx_hi);
    assign dy_seg = DY_W'(tab_deg(idx_hi)) - DY_W'(tab_deg(idx_reg));

    assign dy_mag = dy_reg[DY_W-1] ? DY_W'(-dy_reg) : DY_W'(dy_reg);
    assign prod   = NUM_W'(dx_reg) * NUM_W'(dy_mag);

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign fits    = (rem_sh >= {1'b0, den_reg});
    assign rem_new = fits ? RAW_W'(rem_sh - {1'b0, den_reg}) : rem_sh[RAW_W-1:0];

    assign q_signed = neg_reg ? -$signed({1'b0, num_reg[DY_W-1:0]})
                              : $signed({1'b0, num_reg[DY_W-1:0]});
    assign sum      = SUM_W'(y0_reg) + q_signed;

    assign job_pop = (state_reg == ST_IDLE) && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        kind_reg  <= job.kind;
                        brake_reg <= job.brake;
                        rtd_reg   <= job.rtd;
                        cool_reg  <= job.cool;
                        raw_reg   <= job.raw;
                        idx_reg   <= '0;
                        if (job.kind == KIND_BRAKE || job.kind == KIND_FLAGS) begin
                            temp_reg    <= '0;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else if (job.raw <= x_first) begin
                            temp_reg    <= tab_deg('0);
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else if (job.raw >= x_last) begin
                            temp_reg    <= tab_deg(IDX_LAST);
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (raw_reg <= x_hi) begin
                        dx_reg    <= raw_reg - x_lo;
                        den_reg   <= x_hi - x_lo;
                        y0_reg    <= tab_deg(idx_reg);
                        dy_reg    <= dy_seg;
                        state_reg <= ST_MUL;
                    end else begin
                        idx_reg <= idx_hi;
                    end
                end
                ST_MUL: begin
                    num_reg   <= prod;
                    neg_reg   <= dy_reg[DY_W-1];
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= rem_new;
                    num_reg <= {num_reg[NUM_W-2:0], fits};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    temp_reg    <= sum[TEMP_W-1:0];
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_update_kind     = kind_reg;
    assign m_brake_value     = brake_reg;
    assign m_ready_to_drive  = rtd_reg;
    assign m_cooling_request = cool_reg;
    assign m_temperature     = temp_reg;

    `CFSD_ASSERT_IMPL(a_pop_when_idle, aclk, aresetn, job_pop, !m_valid_reg, "job taken while result pending")
    `CFSD_ASSERT_IMPL(a_valid_in_out, aclk, aresetn, m_valid_reg, state_reg == ST_OUT, "result valid outside output state")
    `CFSD_ASSERT_IMPL(a_rem_below_den, aclk, aresetn, state_reg == ST_DIV, rem_reg < den_reg, "divider remainder out of range")
    `CFSD_ASSERT_IMPL(a_temp_range, aclk, aresetn, m_valid_reg && (kind_reg == KIND_INV || kind_reg == KIND_MOT), temp_reg >= DEG_MIN && temp_reg <= DEG_MAX, "temperature outside table range")

endmodule
